@@ design/csbfm_pkg.sv @@
// Shared types and status codes for the clock-sweep frame manager.
package csbfm_pkg;
	typedef enum logic [2:0] {
		ST_HIT      = 3'd0,
		ST_FREE     = 3'd1,
		ST_EVICT    = 3'd2,
		ST_ALLPIN   = 3'd3,
		ST_REL      = 3'd4,
		ST_RELUNPIN = 3'd5,
		ST_PINOVF   = 3'd6
	} status_t;

	typedef enum logic [0:0] {
		OP_ACCESS  = 1'b0,
		OP_RELEASE = 1'b1
	} op_t;

	localparam logic [0:0] REG_USAGE_LIMIT = 1'd0;
	localparam logic [0:0] REG_WARMUP_DONE = 1'd1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;    // capture the input beat and launch the tag match
		logic decide;  // act on hit/free/release, or start sweeping
		logic sweep;   // visit the frame under the hand
		logic finish;  // sweep gave up: all pinned
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic need_sweep; // the beat is a miss with all frames in use
		logic taken;      // the frame under the hand was claimed this visit
		logic last_visit; // visit budget exhausted with this visit
	} sts_t;
endpackage

@@ design/csbfm_if.sv @@
// Valid/ready channel interfaces for the frame manager.
interface csbfm_req_if;
	logic        valid;
	logic        ready;
	logic [0:0]  operation;
	logic [31:0] table_tag;
	logic [31:0] page_id;
	logic [5:0]  frame_in;
	logic [0:0]  dirty_in;
	modport source (output valid, operation, table_tag, page_id, frame_in, dirty_in,
		input ready);
	modport sink (input valid, operation, table_tag, page_id, frame_in, dirty_in,
		output ready);
endinterface

interface csbfm_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [5:0]  frame_out;
	logic [0:0]  writeback;
	logic [31:0] old_table_id;
	logic [31:0] old_page_id;
	modport source (output valid, status, frame_out, writeback, old_table_id, old_page_id,
		input ready);
	modport sink (input valid, status, frame_out, writeback, old_table_id, old_page_id,
		output ready);
endinterface

interface csbfm_cfg_if;
	logic        valid;
	logic        ready;
	logic [0:0]  index;
	logic [3:0]  data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ design/clock_sweep_buffer_frame_manager.sv @@
// Top level of the clock-sweep page frame manager.
//
// Channel  Dir  Handshake     Beat contents
// req      in   valid/ready   operation, table_tag, page_id, frame_in, dirty_in
// rsp      out  valid/ready   status, frame_out, writeback, old_table_id, old_page_id
// cfg      in   valid/ready   index (0 usage_limit, 1 warmup_done), data
//
// Hits, fills and releases pass through the MATCH and DECIDE states before rsp valid is raised.
// A miss with every frame in use walks the clock hand one frame per cycle,
// so rsp valid comes after at most max(usage_limit,1) * FRAMES visits.
// One beat is in flight at a time; req is ready again the cycle after rsp is taken.
// arst_n clears every frame's valid, pin, usage and dirty state at once.
// cfg is always ready; usage_limit resets to 5 and warmup_done to 1.
module clock_sweep_buffer_frame_manager #(
	parameter int FRAMES   = 64,
	parameter int MAX_PINS = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	csbfm_req_if.sink   req,
	csbfm_rsp_if.source rsp,
	csbfm_cfg_if.sink   cfg
);
	import csbfm_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic [3:0] usage_limit_q;
	logic       warmup_done_q;

	// Configuration registers: always ready.
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			usage_limit_q <= 4'd5;
			warmup_done_q <= 1'b1;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_USAGE_LIMIT: usage_limit_q <= cfg.data;
				REG_WARMUP_DONE: warmup_done_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	csbfm_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid (req.valid), .in_ready (req.ready),
		.out_valid(rsp.valid), .out_ready(rsp.ready),
		.sts, .cmd
	);

	csbfm_dp #(.FRAMES(FRAMES), .MAX_PINS(MAX_PINS)) u_dp (
		.clk, .arst_n, .cmd, .sts,
		.operation(req.operation), .table_tag(req.table_tag), .page_id(req.page_id),
		.frame_in(req.frame_in), .dirty_in(req.dirty_in),
		.usage_limit(usage_limit_q), .warmup_done(warmup_done_q),
		.status(rsp.status), .frame_out(rsp.frame_out), .writeback(rsp.writeback),
		.old_table_id(rsp.old_table_id), .old_page_id(rsp.old_page_id)
	);

	// No new beat while a result is pending.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !req.ready) else $error("req ready while rsp pending");
	// Writeback only with an eviction.
	a_wb_evict: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.writeback) |-> rsp.status == ST_EVICT)
		else $error("writeback without eviction");
	// Result holds until taken.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.status)))
		else $error("result dropped");
endmodule

@@ design/csbfm_ctrl.sv @@
// Controller state machine for the frame manager.
module csbfm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  csbfm_pkg::sts_t   sts,
	output csbfm_pkg::cmd_t   cmd
);
	import csbfm_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_MATCH, S_DECIDE, S_SWEEP, S_OUT} state_t;
	state_t state_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		cmd        = '0;
		cmd.load   = (state_q == S_IDLE) && in_valid;
		cmd.decide = (state_q == S_DECIDE);
		cmd.sweep  = (state_q == S_SWEEP);
		cmd.finish = (state_q == S_SWEEP) && !sts.taken && sts.last_visit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE:   if (in_valid) state_q <= S_MATCH;
				S_MATCH:  state_q <= S_DECIDE;
				S_DECIDE: state_q <= sts.need_sweep ? S_SWEEP : S_OUT;
				S_SWEEP:  if (sts.taken || sts.last_visit) state_q <= S_OUT;
				S_OUT:    if (out_ready) state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end
endmodule

@@ design/csbfm_dp.sv @@
// Frame tables, tag match, free search and clock-sweep datapath.
module csbfm_dp #(
	parameter int FRAMES   = 64,
	parameter int MAX_PINS = 255
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  csbfm_pkg::cmd_t      cmd,
	output csbfm_pkg::sts_t      sts,
	input  logic [0:0]           operation,
	input  logic [31:0]          table_tag,
	input  logic [31:0]          page_id,
	input  logic [5:0]           frame_in,
	input  logic [0:0]           dirty_in,
	input  logic [3:0]           usage_limit,
	input  logic                 warmup_done,
	output logic [2:0]           status,
	output logic [5:0]           frame_out,
	output logic [0:0]           writeback,
	output logic [31:0]          old_table_id,
	output logic [31:0]          old_page_id
);
	import csbfm_pkg::*;

	localparam int FW = $clog2(FRAMES);
	localparam int PW = $clog2(MAX_PINS + 1);
	localparam int CW = $clog2(FRAMES + 1);
	localparam int VW = FW + 4;

	logic [31:0]   tag_t_q [FRAMES];
	logic [31:0]   tag_p_q [FRAMES];
	logic [FRAMES-1:0] valid_q;
	logic [FRAMES-1:0] dirty_q;
	logic [PW-1:0] pin_q   [FRAMES];
	logic [3:0]    usage_q [FRAMES];
	logic [FW-1:0] hand_q;
	logic [CW-1:0] used_q;
	logic [VW-1:0] visits_q;

	logic [0:0]  op_q;
	logic [31:0] t_q, p_q;
	logic [5:0]  fin_q;
	logic        din_q;

	// Registered match and free results.
	logic          hit_q, free_q;
	logic [FW-1:0] hit_idx_q, free_idx_q;

	logic          hit_c, free_c;
	logic [FW-1:0] hit_idx_c, free_idx_c;

	always_comb begin
		hit_c = 1'b0; hit_idx_c = '0;
		free_c = 1'b0; free_idx_c = '0;
		for (int i = FRAMES - 1; i >= 0; i--) begin
			if (valid_q[i] && tag_t_q[i] == t_q && tag_p_q[i] == p_q) begin
				hit_c = 1'b1; hit_idx_c = FW'(i);
			end
			if (!valid_q[i]) begin
				free_c = 1'b1; free_idx_c = FW'(i);
			end
		end
	end

	logic [FW-1:0] rel_idx;
	logic          rel_ok;
	assign rel_idx = FW'(fin_q);
	assign rel_ok  = ({26'd0, fin_q} < 32'(FRAMES)) && valid_q[rel_idx];

	assign sts.need_sweep = (op_q == OP_ACCESS) && !hit_q && !(used_q < CW'(FRAMES));
	assign sts.taken      = (pin_q[hand_q] == '0) && (usage_q[hand_q] == 4'd0);
	assign sts.last_visit = (visits_q == VW'(1));

	logic [VW-1:0] budget;
	assign budget = VW'((usage_limit == 4'd0) ? 4'd1 : usage_limit) * VW'(FRAMES);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= operation; t_q <= table_tag; p_q <= page_id;
			fin_q <= frame_in; din_q <= dirty_in[0];
		end
		hit_q <= hit_c; hit_idx_q <= hit_idx_c;
		free_q <= free_c; free_idx_q <= free_idx_c;
		if (cmd.decide) begin
			visits_q <= budget;
			writeback <= 1'b0; old_table_id <= '0; old_page_id <= '0;
		end else if (cmd.sweep) begin
			visits_q <= visits_q - VW'(1);
		end
		// Tags hold no reset; written on fill and on eviction only.
		if (cmd.decide && op_q == OP_ACCESS && !hit_q && used_q < CW'(FRAMES) && free_q) begin
			tag_t_q[free_idx_q] <= t_q; tag_p_q[free_idx_q] <= p_q;
		end
		if (cmd.sweep && sts.taken) begin
			tag_t_q[hand_q] <= t_q; tag_p_q[hand_q] <= p_q;
			writeback    <= dirty_q[hand_q];
			old_table_id <= tag_t_q[hand_q];
			old_page_id  <= tag_p_q[hand_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0; dirty_q <= '0; hand_q <= '0; used_q <= '0;
			for (int i = 0; i < FRAMES; i++) begin
				pin_q[i] <= '0; usage_q[i] <= '0;
			end
			status <= ST_HIT; frame_out <= '0;
		end else if (cmd.decide) begin
			if (op_q == OP_RELEASE) begin
				frame_out <= fin_q;
				if (!rel_ok) begin
					status <= ST_RELUNPIN;
				end else begin
					if (din_q && warmup_done) begin
						dirty_q[rel_idx] <= 1'b1;
						if (usage_q[rel_idx] < usage_limit)
							usage_q[rel_idx] <= usage_q[rel_idx] + 4'd1;
					end
					if (pin_q[rel_idx] == '0) begin
						status <= ST_RELUNPIN;
					end else begin
						pin_q[rel_idx] <= pin_q[rel_idx] - PW'(1);
						status <= ST_REL;
					end
				end
			end else if (hit_q) begin
				frame_out <= 6'(hit_idx_q);
				if (32'(pin_q[hit_idx_q]) >= 32'(MAX_PINS)) begin
					status <= ST_PINOVF;
				end else begin
					status <= ST_HIT;
					pin_q[hit_idx_q] <= pin_q[hit_idx_q] + PW'(1);
					usage_q[hit_idx_q] <= (usage_q[hit_idx_q] < usage_limit)
						? usage_q[hit_idx_q] + 4'd1 : usage_limit;
				end
			end else if (used_q < CW'(FRAMES)) begin
				if (free_q) begin
					frame_out <= 6'(free_idx_q);
					valid_q[free_idx_q] <= 1'b1;
					dirty_q[free_idx_q] <= 1'b0;
					pin_q[free_idx_q]   <= PW'(1);
					usage_q[free_idx_q] <= 4'd1;
					used_q <= used_q + CW'(1);
					status <= ST_FREE;
				end else begin
					frame_out <= '0;
					status <= ST_ALLPIN;
				end
			end
		end else if (cmd.sweep) begin
			hand_q <= (hand_q == FW'(FRAMES - 1)) ? '0 : hand_q + FW'(1);
			if (sts.taken) begin
				status <= ST_EVICT;
				frame_out <= 6'(hand_q);
				dirty_q[hand_q] <= 1'b0;
				pin_q[hand_q]   <= PW'(1);
				usage_q[hand_q] <= 4'd1;
			end else if (pin_q[hand_q] == '0) begin
				usage_q[hand_q] <= usage_q[hand_q] - 4'd1;
			end
			if (cmd.finish) begin
				status <= ST_ALLPIN;
				frame_out <= '0;
			end
		end
	end
endmodule
